// ----- src/sgc_pkg.sv -----
// Shared types, constants and keyword tables for the memo grammar checker.
`timescale 1ns / 1ps

package sgc_pkg;

  // Default maximum memo length in bytes.
  localparam int MemoMaxDef = 256;

  // Largest legal withdraw share in basis points.
  localparam logic [13:0] ShareMax = 14'd10000;

  // Printable range accepted in a memo.
  localparam logic [7:0] ByteLow  = 8'h21;
  localparam logic [7:0] ByteHigh = 8'h7E;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;

  // Operation keywords. Unused character slots are zero.
  localparam int KwCount = 9;
  localparam int KwSlots = 8;
  localparam logic [3:0] OpLenMax = 4'd9;

  typedef enum logic [1:0] {
    VERDICT_UNPARSED = 2'd0,
    VERDICT_SWAP     = 2'd1,
    VERDICT_ADD      = 2'd2,
    VERDICT_WITHDRAW = 2'd3
  } verdict_e;

  localparam logic [7:0] KwText [KwCount][KwSlots] = '{
    '{8'h53, 8'h57, 8'h41, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},  // SWAP
    '{8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // s
    '{8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // =
    '{8'h41, 8'h44, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ADD
    '{8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // a
    '{8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // +
    '{8'h57, 8'h49, 8'h54, 8'h48, 8'h44, 8'h52, 8'h41, 8'h57},  // WITHDRAW
    '{8'h77, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // wd
    '{8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // -
  };

  localparam logic [3:0] KwLen [KwCount] = '{
    4'd4, 4'd1, 4'd1, 4'd3, 4'd1, 4'd1, 4'd8, 4'd2, 4'd1
  };

  localparam verdict_e KwVerdict [KwCount] = '{
    VERDICT_SWAP, VERDICT_SWAP, VERDICT_SWAP,
    VERDICT_ADD, VERDICT_ADD, VERDICT_ADD,
    VERDICT_WITHDRAW, VERDICT_WITHDRAW, VERDICT_WITHDRAW
  };

  // Per-byte control handed to the field trackers.
  typedef struct packed {
    logic       upd;   // byte belongs to the tracked field
    logic       clr;   // memo ends with this transfer
    logic [7:0] data;
  } step_t;

  // Field 2 share status after the current byte.
  typedef struct packed {
    logic        ok;     // at least one byte seen and all checks passed
    logic [13:0] value;
  } share_t;

endpackage

// ----- src/swap_memo_grammar_checker_core.sv -----
// Top level of the memo grammar checker: memo tracking, verdict and result register.
// The verdict is presented in the cycle after the transfer of the final memo byte.
// Throughput: 1 byte per cycle unless stalled; the per-byte state update and verdict
// logic are combinational between the memo state registers and the result register.
// Every byte waits while a result is held and the output is not ready; a final byte may
// replace a result in the cycle it drains. Reset (rst_ni low) clears state and out_valid.
`timescale 1ns / 1ps

module swap_memo_grammar_checker_core #(
  parameter int MEMO_MAX = sgc_pkg::MemoMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  memo_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [13:0] bps_value_o,
  output logic [7:0]  field_count_o
);

  // The byte counter must hold MEMO_MAX + 1, the saturated over-long mark.
  localparam int CntW = $clog2(MEMO_MAX + 2);
  localparam logic [CntW-1:0] CntLimit = CntW'(MEMO_MAX);
  localparam logic [CntW-1:0] CntSat   = CntW'(MEMO_MAX + 1);

  // Handshake.
  logic accept;
  logic emit;

  // Memo-wide tracking state.
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            prev_sep_q, prev_sep_d;
  logic [7:0]      field_index_q, field_index_d;
  logic [1:0]      dot_total_q, dot_total_d;
  logic [1:0]      dots_pair_q, dots_pair_d;
  logic            bad_q, bad_d;

  // Byte classification.
  logic is_colon;
  logic is_dot;
  logic is_sep;

  // Field trackers.
  sgc_pkg::step_t    op_step;
  sgc_pkg::step_t    share_step;
  sgc_pkg::verdict_e op_verdict;
  sgc_pkg::share_t   share;

  // Result register.
  logic              out_valid_q, out_valid_d;
  sgc_pkg::verdict_e verdict_q, verdict_d;
  logic [13:0]       bps_q, bps_d;
  logic [7:0]        field_count_q, field_count_d;

  // A new byte is taken unless an unclaimed result is still in the register.
  // Non-final bytes produce nothing, so the register only blocks when it
  // cannot be drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && last_byte_i;

  assign is_colon = (memo_byte_i == sgc_pkg::ChColon);
  assign is_dot   = (memo_byte_i == sgc_pkg::ChDot);
  assign is_sep   = is_colon || is_dot;

  // Field 0 feeds the op matcher and field 2 the share accumulator; both see
  // only non-separator bytes, and the field index is the one before this byte.
  assign op_step.upd    = accept && !is_sep && (field_index_q == 8'd0);
  assign op_step.clr    = emit;
  assign op_step.data   = memo_byte_i;
  assign share_step.upd = accept && !is_sep && (field_index_q == 8'd2);
  assign share_step.clr = emit;
  assign share_step.data = memo_byte_i;

  sgc_op_match u_op_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (op_step),
    .op_o   (op_verdict)
  );

  sgc_share_acc u_share_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (share_step),
    .share_o (share)
  );

  // Memo-wide state after the current byte. The verdict below is formed
  // from these next values so the result is ready at the final transfer.
  always_comb begin
    byte_count_d  = byte_count_q;
    prev_sep_d    = prev_sep_q;
    field_index_d = field_index_q;
    dot_total_d   = dot_total_q;
    dots_pair_d   = dots_pair_q;
    bad_d         = bad_q;
    if (accept) begin
      if (byte_count_q <= CntLimit) begin
        byte_count_d = byte_count_q + CntW'(1);
      end
      if (memo_byte_i < sgc_pkg::ByteLow || memo_byte_i > sgc_pkg::ByteHigh) begin
        bad_d = 1'b1;
      end
      // A separator at the start, at the end or after another separator
      // leaves an empty component.
      if (is_sep && (byte_count_q == '0 || prev_sep_q || last_byte_i)) begin
        bad_d = 1'b1;
      end
      if (is_colon) begin
        if (field_index_q != 8'hFF) begin
          field_index_d = field_index_q + 8'd1;
        end
      end else if (is_dot) begin
        if (dot_total_q != 2'd2) begin
          dot_total_d = dot_total_q + 2'd1;
        end
        if (field_index_q == 8'd1 && dots_pair_q != 2'd2) begin
          dots_pair_d = dots_pair_q + 2'd1;
        end
      end
      prev_sep_d = is_sep;
    end
  end

  // Verdict for a memo ending with the current byte.
  always_comb begin
    verdict_d = sgc_pkg::VERDICT_UNPARSED;
    bps_d     = '0;
    if (byte_count_d <= CntLimit && !bad_d && dot_total_d == 2'd1 &&
        dots_pair_d == 2'd1) begin
      verdict_d = op_verdict;
      if (op_verdict == sgc_pkg::VERDICT_WITHDRAW) begin
        if (field_index_d >= 8'd2 && share.ok) begin
          bps_d = share.value;
        end else begin
          verdict_d = sgc_pkg::VERDICT_UNPARSED;
        end
      end
    end
    field_count_d = (field_index_d == 8'hFF) ? 8'hFF : field_index_d + 8'd1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Memo state returns to its reset value once the final byte is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      prev_sep_q    <= 1'b0;
      field_index_q <= '0;
      dot_total_q   <= '0;
      dots_pair_q   <= '0;
      bad_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        byte_count_q  <= '0;
        prev_sep_q    <= 1'b0;
        field_index_q <= '0;
        dot_total_q   <= '0;
        dots_pair_q   <= '0;
        bad_q         <= 1'b0;
      end else begin
        byte_count_q  <= byte_count_d;
        prev_sep_q    <= prev_sep_d;
        field_index_q <= field_index_d;
        dot_total_q   <= dot_total_d;
        dots_pair_q   <= dots_pair_d;
        bad_q         <= bad_d;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      verdict_q     <= verdict_d;
      bps_q         <= bps_d;
      field_count_q <= field_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign bps_value_o   = bps_q;
  assign field_count_o = field_count_q;

  // The saturated counter value is only ever reached, never passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntSat)
    else $error("byte counter passed its saturation value");

  // A share is reported only with a withdraw verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != sgc_pkg::VERDICT_WITHDRAW |-> bps_value_o == 14'd0)
    else $error("nonzero share without a withdraw verdict");

  // A withdraw share never exceeds the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bps_value_o <= sgc_pkg::ShareMax)
    else $error("withdraw share above the cap");

  // Every final byte taken produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> out_valid_o)
    else $error("final byte did not produce a result");

  // An empty result register never holds off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

endmodule

// ----- src/sgc_op_match.sv -----
// Operation keyword matcher for field 0 of the memo.
`timescale 1ns / 1ps

module sgc_op_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgc_pkg::step_t    step_i,
  output sgc_pkg::verdict_e op_o
);

  logic [sgc_pkg::KwCount-1:0] alive_q, alive_d;
  logic [3:0]                  len_q, len_d;

  // Each keyword dies when the op outgrows it or a character differs.
  always_comb begin
    alive_d = alive_q;
    len_d   = len_q;
    if (step_i.upd) begin
      for (int k = 0; k < sgc_pkg::KwCount; k++) begin
        if (len_q >= sgc_pkg::KwLen[k] ||
            sgc_pkg::KwText[k][len_q[2:0]] != step_i.data) begin
          alive_d[k] = 1'b0;
        end
      end
      if (len_q < sgc_pkg::OpLenMax) begin
        len_d = len_q + 4'd1;
      end
    end
  end

  // First keyword that is alive and fully matched wins.
  always_comb begin
    op_o = sgc_pkg::VERDICT_UNPARSED;
    for (int k = sgc_pkg::KwCount - 1; k >= 0; k--) begin
      if (alive_d[k] && len_d == sgc_pkg::KwLen[k]) begin
        op_o = sgc_pkg::KwVerdict[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      len_q   <= '0;
    end else if (step_i.clr) begin
      alive_q <= '1;
      len_q   <= '0;
    end else begin
      alive_q <= alive_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- src/sgc_share_acc.sv -----
// Decimal basis-point accumulator for field 2 of a withdraw memo.
`timescale 1ns / 1ps

module sgc_share_acc (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sgc_pkg::step_t  step_i,
  output sgc_pkg::share_t share_o
);

  logic [13:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic        bad_q, bad_d;
  logic        lz_q, lz_d;

  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] limit;
  logic [17:0] acc_next;

  always_comb begin
    is_digit = step_i.data inside {[8'h30:8'h39]};
    digit    = 4'(step_i.data - sgc_pkg::ChZero);
    // Largest accumulator that still allows one more digit within the cap.
    limit    = (digit == 4'd0) ? 14'd1000 : 14'd999;
    acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {14'd0, digit};

    acc_d  = acc_q;
    seen_d = seen_q;
    bad_d  = bad_q;
    lz_d   = lz_q;
    if (step_i.upd) begin
      // A digit after a leading zero makes the field invalid.
      if (seen_q && lz_q) begin
        bad_d = 1'b1;
      end
      if (!is_digit) begin
        bad_d = 1'b1;
      end else begin
        if (!seen_q && digit == 4'd0) begin
          lz_d = 1'b1;
        end
        if (!bad_d) begin
          if (acc_q > limit) begin
            bad_d = 1'b1;
          end else begin
            acc_d = acc_next[13:0];
          end
        end
      end
      seen_d = 1'b1;
    end
  end

  assign share_o.ok    = seen_d && !bad_d;
  assign share_o.value = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= 1'b0;
      bad_q  <= 1'b0;
      lz_q   <= 1'b0;
    end else if (step_i.clr) begin
      acc_q  <= '0;
      seen_q <= 1'b0;
      bad_q  <= 1'b0;
      lz_q   <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      seen_q <= seen_d;
      bad_q  <= bad_d;
      lz_q   <= lz_d;
    end
  end

endmodule
